// File: rtl/b2da_pkg.sv
// shared types and constants for the binary to decimal ascii converter
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int VALUE_W  = 64;
    localparam int DIGITS   = 20;
    localparam int NIB_W    = 4;
    localparam int BCD_W    = DIGITS * NIB_W;
    localparam int CHAR_W   = 6;
    localparam int COUNT_W  = 5;
    localparam int ITER_W   = $clog2(VALUE_W);

    localparam logic [1:0]         ASCII_ZERO_HI = 2'b11;
    localparam logic [NIB_W-1:0]   NIB_ADJ_MIN   = 4'd5;
    localparam logic [NIB_W-1:0]   NIB_ADJ       = 4'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = COUNT_W'(DIGITS);
    localparam logic [ITER_W-1:0]  ITER_LAST     = ITER_W'(VALUE_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

// File: rtl/binary_to_decimal_ascii_core.sv
// top level: 64-bit unsigned binary to decimal ascii digit stream
//
// usage: drive i_value and raise start; the transfer happens at a rising edge
// with start high and busy low. busy stays high until the last digit is on the
// outputs. the value is converted by a shift-and-add-3 unit, one value bit per
// cycle, into 20 bcd digits; leading zero digits are then
// skipped one per cycle, and the digits go out one per cycle, most significant
// first, each marked by o_valid for exactly one cycle, with o_digit_count on
// every digit and o_is_last on the final one. zero gives a single '0'.
// the digits follow on consecutive cycles; a new value can be taken only once
// busy is low again, after the 64-step conversion loop, the leading-zero skip
// and the digit output. the receiver cannot stall: every digit must be taken
// in the cycle it is shown. reset (synchronous, active low) returns the block
// to idle, drops o_valid and abandons any value in progress.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic [b2da_pkg::VALUE_W-1:0]        i_value,
    output logic                                busy,
    output logic                                o_valid,
    output logic [b2da_pkg::CHAR_W-1:0]         o_digit_char,
    output logic [b2da_pkg::COUNT_W-1:0]        o_digit_count,
    output logic                                o_is_last
);
    import b2da_pkg::*;

    t_state               r_state, n_state;
    logic [VALUE_W-1:0]   r_bin,   n_bin;
    logic [BCD_W-1:0]     r_bcd,   n_bcd;
    logic [ITER_W-1:0]    r_iter,  n_iter;
    logic [COUNT_W-1:0]   r_cnt,   n_cnt;
    logic [COUNT_W-1:0]   r_left,  n_left;
    logic                 r_valid, n_valid;
    logic [CHAR_W-1:0]    r_char,  n_char;
    logic [COUNT_W-1:0]   r_ocnt,  n_ocnt;
    logic                 r_last,  n_last;
    logic [BCD_W-1:0]     adj;
    logic [NIB_W-1:0]     top_nib;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[i*NIB_W +: NIB_W] >= NIB_ADJ_MIN) begin
                adj[i*NIB_W +: NIB_W] = r_bcd[i*NIB_W +: NIB_W] + NIB_ADJ;
            end else begin
                adj[i*NIB_W +: NIB_W] = r_bcd[i*NIB_W +: NIB_W];
            end
        end
    end

    assign top_nib = r_bcd[BCD_W-1 -: NIB_W];

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_iter  = r_iter;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_valid = 1'b0;
        n_char  = r_char;
        n_ocnt  = r_ocnt;
        n_last  = r_last;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_bin   = i_value;
                    n_bcd   = '0;
                    n_iter  = ITER_LAST;
                    n_cnt   = COUNT_MAX;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd  = {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin  = {r_bin[VALUE_W-2:0], 1'b0};
                n_iter = r_iter - 1'b1;
                if (r_iter == '0) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (top_nib == '0 && r_cnt != COUNT_W'(1)) begin
                    n_bcd = {r_bcd[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_left  = r_cnt;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_valid = 1'b1;
                n_char  = {ASCII_ZERO_HI, top_nib};
                n_ocnt  = r_cnt;
                n_last  = (r_left == COUNT_W'(1));
                n_bcd   = {r_bcd[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
                n_left  = r_left - 1'b1;
                if (r_left == COUNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_iter <= n_iter;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_char <= n_char;
        r_ocnt <= n_ocnt;
        r_last <= n_last;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_digit_char  = r_char;
    assign o_digit_count = r_ocnt;
    assign o_is_last     = r_valid & r_last;

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char[5:4] == ASCII_ZERO_HI) && (o_digit_char[3:0] <= 4'd9)
                    && (o_digit_count != '0) && (o_digit_count <= COUNT_MAX))
        else $error("digit out of range");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_last) |=> o_valid && (o_digit_count == $past(o_digit_count)))
        else $error("digit run broken");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_last) |-> !busy ##1 !o_valid)
        else $error("output after last digit");

    a_no_out_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid && busy)
        else $error("output right after transfer");

endmodule
